@@ rtl/inverted_dropout_counter_rng_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the inverted dropout core
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INVERTED_DROPOUT_COUNTER_RNG_CORE_MACROS_SVH
`define INVERTED_DROPOUT_COUNTER_RNG_CORE_MACROS_SVH

// same-cycle implication
`define IDCR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IDCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/idcr_pkg.sv @@
// ----------------------------------------------------------------------------
// idcr_pkg
// Constants, codes and helpers shared by the inverted dropout core.
// ----------------------------------------------------------------------------
package idcr_pkg;

  localparam int MIX_ROUNDS = 10;
  localparam int IDX_W      = 24;
  localparam int VAL_W      = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [63:0] MIX_MUL = 64'hD2B7_4407_B1CE_6E93;
  localparam logic [63:0] GOLDEN  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] XS_MUL  = 64'h2545_F491_4F6C_DD1D;

  localparam logic [1:0] MODE_FWD = 2'd0;
  localparam logic [1:0] MODE_BWD = 2'd1;
  localparam logic [1:0] MODE_INF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd3;

  localparam logic [31:0] FP_ONE = 32'h3F80_0000;

  // sideband that travels beside the random draw
  typedef struct packed {
    logic [1:0]       mode;
    logic             mask;
    logic [VAL_W-1:0] value;
  } sb_t;

  // leading zeros of a nonzero word
  function automatic logic [4:0] lzc32(input logic [31:0] x);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

endpackage

@@ rtl/inverted_dropout_counter_rng_core.sv @@
// ----------------------------------------------------------------------------
// inverted_dropout_counter_rng_core
// Inverted dropout over an fp32 stream with a counter-based random draw.
//
//   port group | direction | handshake          | payload
//   cfg_       | in        | cfg_we             | cfg_index, cfg_wdata
//   in_        | in        | in_valid/in_stall  | first, index, value, mask
//   out_       | out       | out_valid/out_stall| value_out, keep
//
// One input beat per cycle unless out_stall or a seed wait stalls the input;
// stages: entry, ten mix rounds of two, three float stages, output register.
// A forward first-of-tensor beat needs the next seed, made by the registered
// xorshift unit after each seed change; it is held off until that is ready.
// The whole pipe holds while the output beat is stalled.
// Synchronous active-low reset clears valids, config and the running seed.
// ----------------------------------------------------------------------------
`include "inverted_dropout_counter_rng_core_macros.svh"

module inverted_dropout_counter_rng_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [idcr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [idcr_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_first_of_tensor,
  input  logic [idcr_pkg::IDX_W-1:0]         in_element_index,
  input  logic [idcr_pkg::VAL_W-1:0]         in_value_in,
  input  logic                               in_mask_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [idcr_pkg::VAL_W-1:0]         out_value_out,
  output logic                               out_keep
);
  import idcr_pkg::*;

  localparam int         NR      = 2 * MIX_ROUNDS;
  localparam logic [1:0] SETTLED = 2'd3;

  logic [1:0]  mode_r;
  logic [31:0] drop_r, scale_r;
  logic [63:0] running_seed_r;
  logic [1:0]  settle_r;
  logic        out_valid_r;

  logic en, acc, acc_first, seed_chg;
  logic [63:0] seed_use;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en || (in_valid && in_first_of_tensor && mode_r == MODE_FWD
                             && settle_r != SETTLED);
  assign acc       = in_valid && !in_stall;
  assign acc_first = acc && in_first_of_tensor && mode_r == MODE_FWD;
  assign seed_chg  = (cfg_we && cfg_index == REG_SEED) || acc_first;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FWD;
      drop_r  <= 32'd0;
      scale_r <= FP_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode_r  <= cfg_wdata[1:0];
        REG_DROP:  drop_r  <= cfg_wdata[31:0];
        REG_SCALE: scale_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // running seed and its readiness count
  logic [63:0] nxt_seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_seed_r <= 64'd0;
      settle_r       <= 2'd0;
    end else begin
      if (cfg_we && cfg_index == REG_SEED) running_seed_r <= cfg_wdata;
      else if (acc_first)                  running_seed_r <= nxt_seed_r;
      if (seed_chg)                settle_r <= 2'd0;
      else if (settle_r != SETTLED) settle_r <= settle_r + 2'd1;
    end
  end

  // xorshift64* advance, free running behind the running seed
  logic [63:0] xs, xs_r, sp00_r;
  logic [31:0] sp01_r, sp10_r;

  always_comb begin
    xs = (running_seed_r == 64'd0) ? GOLDEN : running_seed_r;
    xs = xs ^ (xs >> 12);
    xs = xs ^ (xs << 25);
    xs = xs ^ (xs >> 27);
  end

  always_ff @(posedge clk) begin
    xs_r       <= xs;
    sp00_r     <= xs_r[31:0] * XS_MUL[31:0];
    sp01_r     <= xs_r[31:0] * XS_MUL[63:32];
    sp10_r     <= xs_r[63:32] * XS_MUL[31:0];
    nxt_seed_r <= sp00_r + {sp01_r + sp10_r, 32'd0};
  end

  assign seed_use = acc_first ? nxt_seed_r : running_seed_r;

  // entry stage and sideband line
  logic [NR:0] vld_r;
  sb_t         sb_r [0:NR];
  logic [63:0] ctr0_r, key0_r;
  logic [63:0] ctr_w [0:MIX_ROUNDS];
  logic [63:0] klo_w [0:MIX_ROUNDS];
  logic [63:0] khi_w [0:MIX_ROUNDS];

  always_ff @(posedge clk) begin
    if (!rst_n)  vld_r <= '0;
    else if (en) vld_r <= {vld_r[NR-1:0], acc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0].mode  <= mode_r;
      sb_r[0].mask  <= in_mask_in;
      sb_r[0].value <= in_value_in;
      ctr0_r        <= seed_use + {{(64-IDX_W){1'b0}}, in_element_index};
      key0_r        <= seed_use ^ GOLDEN;
      for (int i = 1; i <= NR; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  assign ctr_w[0] = ctr0_r;
  assign klo_w[0] = key0_r;
  assign khi_w[0] = key0_r;

  for (genvar g = 0; g < MIX_ROUNDS; g++) begin : g_round
    idcr_round u_round (
      .clk   (clk),
      .en    (en),
      .ctr_i (ctr_w[g]),
      .klo_i (klo_w[g]),
      .khi_i (khi_w[g]),
      .ctr_o (ctr_w[g+1]),
      .klo_o (klo_w[g+1]),
      .khi_o (khi_w[g+1])
    );
  end

  // tail: uniform conversion, compare, scale multiply
  logic        vld_t1_r, vld_t2_r, vld_t3_r;
  sb_t         sb_t1_r, sb_t2_r, sb_t3_r;
  logic [31:0] u_top, n1_r;
  logic [4:0]  lz1_r;
  logic        nz1_r, drop2_r, drop3_r;
  logic [31:0] mul_res;

  assign u_top = ctr_w[MIX_ROUNDS][63:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_t1_r <= 1'b0;
      vld_t2_r <= 1'b0;
      vld_t3_r <= 1'b0;
    end else if (en) begin
      vld_t1_r <= vld_r[NR];
      vld_t2_r <= vld_t1_r;
      vld_t3_r <= vld_t2_r;
    end
  end

  // round the draw to fp32, already scaled by 2^-32
  logic [7:0]  rexp;
  logic        rrnd, pnan, lt;
  logic [31:0] rbits;

  always_comb begin
    rexp  = 8'd126 - {3'd0, lz1_r};
    rrnd  = n1_r[7] && ((|n1_r[6:0]) || n1_r[8]);
    rbits = nz1_r ? ({1'b0, rexp, n1_r[30:8]} + {31'd0, rrnd}) : 32'd0;
    pnan  = (drop_r[30:23] == 8'hFF) && (drop_r[22:0] != 23'd0);
    lt    = !drop_r[31] && !pnan && (rbits < drop_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_t1_r <= sb_r[NR];
      sb_t2_r <= sb_t1_r;
      sb_t3_r <= sb_t2_r;
      lz1_r   <= lzc32(u_top);
      n1_r    <= u_top << lzc32(u_top);
      nz1_r   <= u_top != 32'd0;
      drop2_r <= lt;
      drop3_r <= drop2_r;
    end
  end

  idcr_fmul u_fmul (
    .clk   (clk),
    .en    (en),
    .a_i   (sb_r[NR].value),
    .b_i   (scale_r),
    .res_o (mul_res)
  );

  // output register
  logic        out_keep_r, keep_nxt;
  logic [31:0] out_value_r, value_nxt;
  logic [1:0]  out_mode_r;

  always_comb begin
    case (sb_t3_r.mode)
      MODE_FWD: begin
        value_nxt = drop3_r ? 32'd0 : mul_res;
        keep_nxt  = !drop3_r;
      end
      MODE_BWD: begin
        value_nxt = sb_t3_r.mask ? mul_res : 32'd0;
        keep_nxt  = sb_t3_r.mask;
      end
      default: begin
        value_nxt = sb_t3_r.value;
        keep_nxt  = sb_t3_r.mask;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)  out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld_t3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= value_nxt;
      out_keep_r  <= keep_nxt;
      out_mode_r  <= sb_t3_r.mode;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_keep      = out_keep_r;

  `IDCR_ASSERT_SAME(a_seed_ready, acc_first, settle_r == SETTLED, "seed taken before ready")
  `IDCR_ASSERT_NEXT(a_seed_hold, !seed_chg, $stable(running_seed_r), "seed moved unasked")
  `IDCR_ASSERT_SAME(a_drop_zero, out_valid_r && out_mode_r == MODE_FWD && !out_keep_r, out_value_r == 32'd0, "dropped beat not zero")
  `IDCR_ASSERT_NEXT(a_tail_flow, vld_r[NR] && en, vld_t1_r, "beat lost leaving mix rounds")

endmodule

@@ rtl/idcr_round.sv @@
// ----------------------------------------------------------------------------
// idcr_round
// One mix round: 64x64 product split into four 32x32 partial products,
// then summed and folded into the counter and keys. Two register stages.
// ----------------------------------------------------------------------------
module idcr_round (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] ctr_i,
  input  logic [63:0] klo_i,
  input  logic [63:0] khi_i,
  output logic [63:0] ctr_o,
  output logic [63:0] klo_o,
  output logic [63:0] khi_o
);
  import idcr_pkg::*;

  logic [63:0] p00_r, p01_r, p10_r, p11_r;
  logic [63:0] klo_a_r, khi_a_r;
  logic [63:0] ctr_r, klo_r, khi_r;
  logic [63:0] mid, lo, hi;

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r   <= MIX_MUL[31:0]  * ctr_i[31:0];
      p01_r   <= MIX_MUL[31:0]  * ctr_i[63:32];
      p10_r   <= MIX_MUL[63:32] * ctr_i[31:0];
      p11_r   <= MIX_MUL[63:32] * ctr_i[63:32];
      klo_a_r <= klo_i;
      khi_a_r <= khi_i;
    end
  end

  always_comb begin
    mid = {32'd0, p00_r[63:32]} + {32'd0, p01_r[31:0]} + {32'd0, p10_r[31:0]};
    lo  = {mid[31:0], p00_r[31:0]};
    hi  = p11_r + {32'd0, p01_r[63:32]} + {32'd0, p10_r[63:32]} + {32'd0, mid[63:32]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctr_r <= hi ^ klo_a_r ^ khi_a_r;
      klo_r <= lo;
      khi_r <= lo ^ khi_a_r;
    end
  end

  assign ctr_o = ctr_r;
  assign klo_o = klo_r;
  assign khi_o = khi_r;

endmodule

@@ rtl/idcr_fmul.sv @@
// ----------------------------------------------------------------------------
// idcr_fmul
// fp32 multiply, round to nearest even, subnormals in and out. Three register
// stages (unpack, product, normalise); the rounding add is left to the caller's
// output register.
// ----------------------------------------------------------------------------
module idcr_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);
  import idcr_pkg::*;

  function automatic logic [4:0] lzc24(input logic [23:0] x);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  // stage 1: unpack
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn, spec;
  logic [31:0] sres;
  logic [23:0] ma, mb;
  logic [4:0]  lza, lzb;
  logic signed [9:0] ea, eb;

  always_comb begin
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = (a_i[30:0] == 31'd0);
    b_zero = (b_i[30:0] == 31'd0);
    sgn    = a_i[31] ^ b_i[31];
    spec   = 1'b1;
    if (a_nan)                                   sres = a_i | 32'h0040_0000;
    else if (b_nan)                              sres = b_i | 32'h0040_0000;
    else if ((a_inf && b_zero) || (b_inf && a_zero)) sres = 32'hFFC0_0000;
    else if (a_inf || b_inf)                     sres = {sgn, 8'hFF, 23'd0};
    else if (a_zero || b_zero)                   sres = {sgn, 31'd0};
    else begin
      sres = 32'd0;
      spec = 1'b0;
    end
    lza = lzc24({a_i[30:23] != 8'd0, a_i[22:0]});
    lzb = lzc24({b_i[30:23] != 8'd0, b_i[22:0]});
    ma  = {a_i[30:23] != 8'd0, a_i[22:0]} << lza;
    mb  = {b_i[30:23] != 8'd0, b_i[22:0]} << lzb;
    ea  = ((a_i[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, a_i[30:23]}))
          - $signed({5'd0, lza});
    eb  = ((b_i[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, b_i[30:23]}))
          - $signed({5'd0, lzb});
  end

  logic        spec1_r, sgn1_r;
  logic [31:0] sres1_r;
  logic [23:0] ma1_r, mb1_r;
  logic signed [9:0] e1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r <= spec;
      sgn1_r  <= sgn;
      sres1_r <= sres;
      ma1_r   <= ma;
      mb1_r   <= mb;
      e1_r    <= ea + eb - 10'sd127;
    end
  end

  // stage 2: product
  logic        spec2_r, sgn2_r;
  logic [31:0] sres2_r;
  logic [47:0] p2_r;
  logic signed [9:0] e2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      spec2_r <= spec1_r;
      sgn2_r  <= sgn1_r;
      sres2_r <= sres1_r;
      p2_r    <= ma1_r * mb1_r;
      e2_r    <= e1_r;
    end
  end

  // stage 3: normalise, denormalise below the smallest normal
  logic [47:0] m, mshift;
  logic signed [9:0] e, shf;
  logic [5:0]  sh;
  logic        stx, ovf;
  logic [7:0]  expf;

  always_comb begin
    if (p2_r[47]) begin
      m = p2_r;
      e = e2_r + 10'sd1;
    end else begin
      m = {p2_r[46:0], 1'b0};
      e = e2_r;
    end
    ovf = e > 10'sd254;
    shf = 10'sd1 - e;
    sh  = (shf > 10'sd48) ? 6'd48 : shf[5:0];
    if (e < 10'sd1) begin
      mshift = m >> sh;
      stx    = |(m & ~({48{1'b1}} << sh));
      expf   = 8'd0;
    end else begin
      mshift = m;
      stx    = 1'b0;
      expf   = e[7:0];
    end
  end

  logic        spec3_r, sgn3_r, ovf3_r, stx3_r;
  logic [31:0] sres3_r;
  logic [47:0] m3_r;
  logic [7:0]  expf3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      spec3_r <= spec2_r;
      sgn3_r  <= sgn2_r;
      sres3_r <= sres2_r;
      ovf3_r  <= ovf;
      stx3_r  <= stx;
      m3_r    <= mshift;
      expf3_r <= expf;
    end
  end

  // round to nearest even; carry may step into the exponent or to infinity
  logic        rnd;
  logic [30:0] mag;

  always_comb begin
    rnd = m3_r[23] && (stx3_r || (|m3_r[22:0]) || m3_r[24]);
    mag = {expf3_r, m3_r[46:24]} + {30'd0, rnd};
    if (spec3_r)     res_o = sres3_r;
    else if (ovf3_r) res_o = {sgn3_r, 8'hFF, 23'd0};
    else             res_o = {sgn3_r, mag};
  end

endmodule
